FILE: hdl/assert_macros.svh
// Assertion helpers for the alarm queue timer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hdl/aqt_pkg.sv
`timescale 1ns / 1ps
package aqt_pkg;

    localparam int ALARMS_DEF   = 16;
    localparam int COUNTERS_DEF = 2;
    localparam int FIRE_CAP     = 16;

    localparam logic [4:0] NO_LINK = 5'd31;

    localparam logic [2:0] MODE_SET_REL = 3'd0;
    localparam logic [2:0] MODE_SET_ABS = 3'd1;
    localparam logic [2:0] MODE_CANCEL  = 3'd2;
    localparam logic [2:0] MODE_GET     = 3'd3;
    localparam logic [2:0] MODE_TICK    = 3'd4;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_ID     = 3'd1;
    localparam logic [2:0] ST_STATE  = 3'd2;
    localparam logic [2:0] ST_NOFUNC = 3'd3;
    localparam logic [2:0] ST_VALUE  = 3'd4;

    localparam logic [2:0] REG_MAX0 = 3'd0;
    localparam logic [2:0] REG_MAX1 = 3'd1;
    localparam logic [2:0] REG_MIN0 = 3'd2;
    localparam logic [2:0] REG_MIN1 = 3'd3;
    localparam logic [2:0] REG_MAP  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_ENQ,
        S_LINK_ENQ,
        S_TICK_HEAD,
        S_TICK_CHECK,
        S_TICK_UNLINK,
        S_TICK_DONE
    } aqt_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic decode;
        logic scan_step;
        logic link;
        logic tick_adv;
        logic fire_check;
        logic fire_unlink;
        logic emit;
    } aqt_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic is_tick;
        logic is_arm;
        logic is_cancel;
        logic immediate;
        logic scan_done;
        logic fire_now;
        logic rearm;
        logic pend;
    } aqt_stat_t;

    function automatic logic [16:0] add_ticks(input logic [16:0] a, input logic [16:0] inc,
                                              input logic [16:0] m2);
        logic [17:0] s;
        s = {1'b0, a} + {1'b0, inc};
        if (s > {1'b0, m2})
            s = s - ({1'b0, m2} + 18'd1);
        return s[16:0];
    endfunction

endpackage

FILE: hdl/aqt_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aqt_datapath
    import aqt_pkg::*;
#(
    parameter int ALARMS   = ALARMS_DEF,
    parameter int COUNTERS = COUNTERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  aqt_cmd_t    cmd,
    output aqt_stat_t   stat,
    input  logic [2:0]  mode,
    input  logic [4:0]  alarm_id,
    input  logic [15:0] tick_value,
    input  logic [15:0] cycle,
    input  logic        counter_id,
    input  logic [15:0] max0,
    input  logic [15:0] max1,
    input  logic [15:0] min0,
    input  logic [15:0] min1,
    input  logic [15:0] cmap,
    output logic        res_valid,
    output logic [2:0]  res_status,
    output logic [16:0] res_remaining,
    output logic        res_exp_valid,
    output logic [3:0]  res_exp_alarm,
    output logic        res_last
);

    localparam int AW = (ALARMS > 1) ? $clog2(ALARMS) : 1;

    logic [2:0]  mode_reg;
    logic [4:0]  id_reg;
    logic [15:0] tv_reg;
    logic [15:0] cyc_reg;
    logic        cid_reg;

    logic [16:0] cnt_reg [COUNTERS];
    logic [16:0] exp_reg [ALARMS];
    logic [15:0] per_reg [ALARMS];
    logic [ALARMS-1:0] act_reg;
    logic [ALARMS-1:0] sel_reg;
    logic [4:0] nxt_reg [ALARMS];
    logic [4:0] prv_reg [ALARMS];
    logic [4:0] head_reg [COUNTERS];

    // Walk state for insert and tick.
    logic [AW-1:0] tgt_reg;
    logic          tc_reg;
    logic [4:0]    wp_reg;
    logic [4:0]    wn_reg;
    logic [5:0]    wcnt_reg;
    logic          wphase_reg;
    logic [4:0]    fa_reg;
    logic [4:0]    fnext_reg;
    logic [4:0]    fired_reg;
    logic          tick_done_reg;
    logic          pend_valid_reg;
    logic [3:0]    pend_alarm_reg;

    logic        res_valid_reg;
    logic [2:0]  res_status_reg;
    logic [16:0] res_rem_reg;
    logic        res_ev_reg;
    logic [3:0]  res_ea_reg;
    logic        res_last_reg;

    logic [AW-1:0] id_a;
    logic          arm_c;
    logic [15:0]   mx_arm;
    logic [15:0]   mn_arm;
    logic          sel_c;
    logic [15:0]   mx_sel;
    logic [16:0]   m2_tick;
    logic [16:0]   m2_sel;
    logic [16:0]   cnt_tick;
    logic [16:0]   cnt_sel;
    logic [16:0]   cnt_tc;
    logic          wn_ok;
    logic [AW-1:0] wn_a;
    logic          fa_ok;
    logic [AW-1:0] fa_a;
    logic [16:0]   behind_v;
    logic [2:0]    imm_status;
    logic [16:0]   imm_rem;
    logic          cid_bad;
    logic          id_bad;
    logic          skip_c;

    assign id_a    = id_reg[AW-1:0];
    assign arm_c   = (COUNTERS > 1) ? cmap[id_reg[3:0]] : 1'b0;
    assign mx_arm  = arm_c ? max1 : max0;
    assign mn_arm  = arm_c ? min1 : min0;
    assign sel_c   = (COUNTERS > 1) ? sel_reg[id_a] : 1'b0;
    assign mx_sel  = sel_c ? max1 : max0;
    assign m2_tick = (cid_reg ? {max1, 1'b0} : {max0, 1'b0});
    assign m2_sel  = {mx_sel, 1'b0};
    assign cnt_tick = cnt_reg[(COUNTERS > 1) ? int'(cid_reg) : 0];
    assign cnt_sel  = cnt_reg[(COUNTERS > 1) ? int'(sel_c) : 0];
    assign cnt_tc   = cnt_reg[(COUNTERS > 1) ? int'(tc_reg) : 0];
    assign wn_ok   = (wn_reg < 5'(ALARMS));
    assign wn_a    = wn_reg[AW-1:0];
    assign fa_ok   = (fa_reg < 5'(ALARMS));
    assign fa_a    = fa_reg[AW-1:0];
    assign cid_bad = ({4'd0, cid_reg} >= 5'(COUNTERS));
    assign id_bad  = (id_reg >= 5'(ALARMS));
    assign skip_c  = (exp_reg[tgt_reg] < cnt_tc) && (exp_reg[wn_a] > cnt_tc);

    always_comb
    begin
        if (cnt_tick >= exp_reg[fa_a])
            behind_v = cnt_tick - exp_reg[fa_a];
        else
            behind_v = m2_tick - exp_reg[fa_a] + cnt_tick + 17'd1;
    end

    // Immediate answer of a command.
    always_comb
    begin
        imm_status = ST_OK;
        imm_rem    = '0;
        priority if (mode_reg > MODE_TICK)
            imm_status = ST_VALUE;
        else if (id_bad)
            imm_status = ST_ID;
        else if (mode_reg == MODE_SET_REL || mode_reg == MODE_SET_ABS)
        begin
            if (act_reg[id_a])
                imm_status = ST_STATE;
            else if ({1'b0, tv_reg} > {1'b0, mx_arm} || cyc_reg > mx_arm
                     || (cyc_reg != 16'd0 && cyc_reg < mn_arm))
                imm_status = ST_VALUE;
        end
        else if (!act_reg[id_a])
            imm_status = ST_NOFUNC;
        else if (mode_reg == MODE_GET)
        begin
            if (cnt_sel < exp_reg[id_a])
                imm_rem = exp_reg[id_a] - cnt_sel;
            else
                imm_rem = m2_sel + 17'd1 - cnt_sel + exp_reg[id_a];
        end
    end

    always_comb
    begin
        stat.is_tick   = (mode_reg == MODE_TICK) && !cid_bad;
        stat.is_arm    = (mode_reg == MODE_SET_REL || mode_reg == MODE_SET_ABS)
                         && imm_status == ST_OK;
        stat.is_cancel = (mode_reg == MODE_CANCEL) && imm_status == ST_OK;
        stat.immediate = !stat.is_tick;
        stat.scan_done = !wn_ok || wcnt_reg >= 6'(ALARMS)
                         || (!wphase_reg && !(exp_reg[wn_a] < exp_reg[tgt_reg]));
        stat.fire_now  = fa_ok && !tick_done_reg && ({1'b0, fired_reg} < 6'(FIRE_CAP))
                         && behind_v <= {1'b0, (cid_reg ? max1 : max0)};
        stat.rearm     = per_reg[fa_a] != 16'd0;
        stat.pend      = pend_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            id_reg   <= alarm_id;
            tv_reg   <= tick_value;
            cyc_reg  <= cycle;
            cid_reg  <= counter_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.decode && stat.is_arm)
        begin
            if (mode_reg == MODE_SET_REL)
                exp_reg[id_a] <= add_ticks(cnt_reg[(COUNTERS > 1) ? int'(arm_c) : 0],
                                           {1'b0, tv_reg}, {mx_arm, 1'b0});
            else
                exp_reg[id_a] <= {1'b0, tv_reg};
            per_reg[id_a] <= cyc_reg;
        end
        else if (cmd.fire_unlink && stat.rearm)
            exp_reg[fa_a] <= add_ticks(cnt_tick, {1'b0, per_reg[fa_a]}, m2_tick);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COUNTERS; i++)
            begin
                cnt_reg[i]  <= '0;
                head_reg[i] <= NO_LINK;
            end
            for (int i = 0; i < ALARMS; i++)
            begin
                nxt_reg[i] <= NO_LINK;
                prv_reg[i] <= NO_LINK;
            end
            act_reg        <= '0;
            sel_reg        <= '0;
            tgt_reg        <= '0;
            tc_reg         <= 1'b0;
            wp_reg         <= NO_LINK;
            wn_reg         <= NO_LINK;
            wcnt_reg       <= '0;
            wphase_reg     <= 1'b0;
            fa_reg         <= NO_LINK;
            fnext_reg      <= NO_LINK;
            fired_reg      <= '0;
            tick_done_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_alarm_reg <= '0;
        end
        else
        begin
            if (cmd.decode)
            begin
                if (stat.is_arm)
                begin
                    sel_reg[id_a] <= arm_c;
                    act_reg[id_a] <= 1'b1;
                    tgt_reg       <= id_a;
                    tc_reg        <= arm_c;
                    wp_reg        <= NO_LINK;
                    wn_reg        <= head_reg[(COUNTERS > 1) ? int'(arm_c) : 0];
                    wcnt_reg      <= '0;
                    wphase_reg    <= 1'b1;
                end
                else if (stat.is_cancel)
                begin
                    act_reg[id_a] <= 1'b0;
                    if (prv_reg[id_a] < 5'(ALARMS))
                        nxt_reg[prv_reg[id_a][AW-1:0]] <= nxt_reg[id_a];
                    else
                        head_reg[(COUNTERS > 1) ? int'(sel_c) : 0] <= nxt_reg[id_a];
                    if (nxt_reg[id_a] < 5'(ALARMS))
                        prv_reg[nxt_reg[id_a][AW-1:0]] <= prv_reg[id_a];
                    nxt_reg[id_a] <= NO_LINK;
                    prv_reg[id_a] <= NO_LINK;
                end
            end
            if (cmd.scan_step && !stat.scan_done)
            begin
                // First phase skips entries past the counter when target wrapped.
                if (wphase_reg && !skip_c)
                    wphase_reg <= 1'b0;
                else
                begin
                    wp_reg   <= wn_reg;
                    wn_reg   <= nxt_reg[wn_a];
                    wcnt_reg <= wcnt_reg + 6'd1;
                end
            end
            if (cmd.link)
            begin
                nxt_reg[tgt_reg] <= wn_ok ? wn_reg : NO_LINK;
                prv_reg[tgt_reg] <= wp_reg;
                if (wp_reg < 5'(ALARMS))
                    nxt_reg[wp_reg[AW-1:0]] <= {{(5-AW){1'b0}}, tgt_reg};
                else
                    head_reg[(COUNTERS > 1) ? int'(tc_reg) : 0] <= {{(5-AW){1'b0}}, tgt_reg};
                if (wn_ok)
                    prv_reg[wn_a] <= {{(5-AW){1'b0}}, tgt_reg};
            end
            if (cmd.tick_adv)
            begin
                cnt_reg[(COUNTERS > 1) ? int'(cid_reg) : 0] <= add_ticks(cnt_tick, 17'd1, m2_tick);
                fnext_reg      <= head_reg[(COUNTERS > 1) ? int'(cid_reg) : 0];
                fired_reg      <= '0;
                tick_done_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.fire_check)
            begin
                fa_reg    <= fnext_reg;
            end
            if (cmd.fire_unlink)
            begin
                fnext_reg      <= nxt_reg[fa_a];
                fired_reg      <= fired_reg + 5'd1;
                pend_valid_reg <= 1'b1;
                pend_alarm_reg <= fa_reg[3:0];
                if (prv_reg[fa_a] < 5'(ALARMS))
                    nxt_reg[prv_reg[fa_a][AW-1:0]] <= nxt_reg[fa_a];
                else
                    head_reg[(COUNTERS > 1) ? int'(cid_reg) : 0] <= nxt_reg[fa_a];
                if (nxt_reg[fa_a] < 5'(ALARMS))
                    prv_reg[nxt_reg[fa_a][AW-1:0]] <= prv_reg[fa_a];
                nxt_reg[fa_a] <= NO_LINK;
                prv_reg[fa_a] <= NO_LINK;
                if (stat.rearm)
                begin
                    tgt_reg    <= fa_a;
                    tc_reg     <= cid_reg;
                    wp_reg     <= NO_LINK;
                    wn_reg     <= (prv_reg[fa_a] < 5'(ALARMS))
                                  ? head_reg[(COUNTERS > 1) ? int'(cid_reg) : 0]
                                  : nxt_reg[fa_a];
                    wcnt_reg   <= '0;
                    wphase_reg <= 1'b1;
                end
                else
                    act_reg[fa_a] <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.fire_unlink)
            begin
                res_status_reg <= ST_OK;
                res_rem_reg    <= '0;
                res_ev_reg     <= 1'b1;
                res_ea_reg     <= pend_alarm_reg;
                res_last_reg   <= 1'b0;
            end
            else if (stat.is_tick)
            begin
                res_status_reg <= ST_OK;
                res_rem_reg    <= '0;
                res_ev_reg     <= pend_valid_reg;
                res_ea_reg     <= pend_valid_reg ? pend_alarm_reg : 4'd0;
                res_last_reg   <= 1'b1;
            end
            else
            begin
                res_status_reg <= (mode_reg == MODE_TICK) ? ST_ID : imm_status;
                res_rem_reg    <= imm_rem;
                res_ev_reg     <= 1'b0;
                res_ea_reg     <= '0;
                res_last_reg   <= 1'b1;
            end
        end
    end

    assign res_valid     = res_valid_reg;
    assign res_status    = res_status_reg;
    assign res_remaining = res_rem_reg;
    assign res_exp_valid = res_ev_reg;
    assign res_exp_alarm = res_ea_reg;
    assign res_last      = res_last_reg;

    `ASSERT_CLK(a_fire_cap, clk, rst_n, fired_reg <= 5'(FIRE_CAP), "fire count overflow")
    `ASSERT_IMP(a_link_target, clk, rst_n, cmd.link, act_reg[tgt_reg], "link of stopped alarm")
    `ASSERT_IMP(a_emit_one, clk, rst_n, cmd.emit, !(cmd.link || cmd.scan_step),
                "emit during insert")

endmodule

FILE: hdl/aqt_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module aqt_ctrl
    import aqt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  aqt_stat_t stat,
    output aqt_cmd_t  cmd,
    output logic      busy
);

    aqt_state_t state_reg;
    aqt_state_t state_next;
    logic       in_tick_reg;
    logic       in_tick_next;

    always_comb
    begin
        state_next   = state_reg;
        in_tick_next = in_tick_reg;
        unique case (state_reg)
            S_IDLE:
                if (start)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                in_tick_next = 1'b0;
                priority if (stat.is_tick)
                    state_next = S_TICK_HEAD;
                else if (stat.is_arm)
                    state_next = S_SCAN_ENQ;
                else
                    state_next = S_IDLE;
            end
            S_SCAN_ENQ:
                if (stat.scan_done)
                    state_next = S_LINK_ENQ;
            S_LINK_ENQ:
                state_next = in_tick_reg ? S_TICK_CHECK : S_IDLE;
            S_TICK_HEAD:
            begin
                in_tick_next = 1'b1;
                state_next   = S_TICK_CHECK;
            end
            S_TICK_CHECK:
                state_next = S_TICK_UNLINK;
            S_TICK_UNLINK:
                priority if (stat.fire_now)
                    state_next = stat.rearm ? S_SCAN_ENQ : S_TICK_CHECK;
                else
                    state_next = S_TICK_DONE;
            S_TICK_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
                cmd.load = start;
            S_DECODE:
            begin
                cmd.decode   = 1'b1;
                cmd.emit     = stat.immediate;
                cmd.tick_adv = stat.is_tick;
            end
            S_SCAN_ENQ:
                cmd.scan_step = 1'b1;
            S_LINK_ENQ:
                cmd.link = 1'b1;
            S_TICK_HEAD:
                cmd.fire_check = 1'b0;
            S_TICK_CHECK:
                cmd.fire_check = 1'b1;
            S_TICK_UNLINK:
            begin
                cmd.fire_unlink = stat.fire_now;
                cmd.emit        = stat.fire_now && stat.pend;
            end
            S_TICK_DONE:
                cmd.emit = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            in_tick_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_tick_reg <= in_tick_next;
        end
    end

    `ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, state_reg == S_IDLE, "load while busy")
    `ASSERT_IMP(a_start_decode, clk, rst_n, start && !busy, ##1 state_reg == S_DECODE,
                "start not taken")
    `ASSERT_IMP(a_unlink_in_tick, clk, rst_n, cmd.fire_unlink, in_tick_reg,
                "unlink outside tick")

endmodule

FILE: hdl/alarm_queue_timer_unit.sv
// Alarm queue timer: two wrapping tick counters and sixteen alarms.
// Command channel: drive mode, alarm_id, tick_value, cycle and counter_id
// with start high; the word is taken at an edge where busy is low.
// Result channel: each word shows for one cycle with result_valid high;
// last marks the final word of a command. The receiver cannot stall.
// Sequence: a plain command keeps busy high only in the decode state,
// which registers its word. Arming keeps busy high while it walks the
// counter's queue entry by entry and then links the alarm in. A tick
// advances the counter, then for each fired alarm checks and unlinks it,
// and walks the queue and links again each re-armed one; its last word
// follows busy.
// Configuration: APB writes at byte address 4*i, registers of 16 bits.
// Reset clears counters, active marks and queues; expiry and period stay
// undefined until an alarm is armed.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module alarm_queue_timer_unit
    import aqt_pkg::*;
#(
    parameter int ALARMS   = ALARMS_DEF,
    parameter int COUNTERS = COUNTERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [4:0]  alarm_id,
    input  logic [15:0] tick_value,
    input  logic [15:0] cycle,
    input  logic        counter_id,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [16:0] remaining_ticks,
    output logic        expired_valid,
    output logic [3:0]  expired_alarm,
    output logic        last
);

    logic [15:0] max0_reg;
    logic [15:0] max1_reg;
    logic [15:0] min0_reg;
    logic [15:0] min1_reg;
    logic [15:0] map_reg;
    logic        wr_en;
    aqt_cmd_t    cmd;
    aqt_stat_t   stat;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max0_reg <= 16'hFFFF;
            max1_reg <= 16'hFFFF;
            min0_reg <= 16'd1;
            min1_reg <= 16'd1;
            map_reg  <= '0;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[4:2])
                REG_MAX0: max0_reg <= pwdata[15:0];
                REG_MAX1: max1_reg <= pwdata[15:0];
                REG_MIN0: min0_reg <= pwdata[15:0];
                REG_MIN1: min1_reg <= pwdata[15:0];
                REG_MAP:  map_reg  <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MAX0: prdata = {16'd0, max0_reg};
            REG_MAX1: prdata = {16'd0, max1_reg};
            REG_MIN0: prdata = {16'd0, min0_reg};
            REG_MIN1: prdata = {16'd0, min1_reg};
            REG_MAP:  prdata = {16'd0, map_reg};
            default:  prdata = '0;
        endcase
    end

    aqt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    aqt_datapath #(
        .ALARMS   (ALARMS),
        .COUNTERS (COUNTERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .mode          (mode),
        .alarm_id      (alarm_id),
        .tick_value    (tick_value),
        .cycle         (cycle),
        .counter_id    (counter_id),
        .max0          (max0_reg),
        .max1          (max1_reg),
        .min0          (min0_reg),
        .min1          (min1_reg),
        .cmap          (map_reg),
        .res_valid     (result_valid),
        .res_status    (status),
        .res_remaining (remaining_ticks),
        .res_exp_valid (expired_valid),
        .res_exp_alarm (expired_alarm),
        .res_last      (last)
    );

    `ASSERT_IMP(a_result_idle, clk, rst_n, result_valid && last, ##1 !result_valid,
                "extra word after last")

endmodule
